FILE: hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, function codes, fit modes and register indexes for the
// partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   localparam int MAX_PARTS     = 16;
   localparam int SIZE_BITS     = 16;
   localparam int IDX_BITS      = $clog2(MAX_PARTS);
   localparam int CNT_BITS      = $clog2(MAX_PARTS + 1);
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 5;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // func codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_ALLOC   = 2'd1;
   localparam logic [1:0] FUNC_RESTORE = 2'd2;

   // fit modes
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_FIT_MODE   = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] REG_PART_COUNT = CSR_ADDR_BITS'(1);

endpackage

`default_nettype wire

FILE: hdl/pfa_ifs.sv
// ----------------------------------------------------------------------------
// pfa channel interfaces
// Request, response and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_req_if;
   import pfa_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   idx_type    part_index;
   size_type   size_value;

   modport source (output valid, func, part_index, size_value, input ready);
   modport sink   (input valid, func, part_index, size_value, output ready);
endinterface

interface pfa_rsp_if;
   import pfa_pkg::*;
   logic     valid;
   logic     ready;
   logic     granted;
   idx_type  block_index;
   size_type space_left;

   modport source (output valid, granted, block_index, space_left, input ready);
   modport sink   (input valid, granted, block_index, space_left, output ready);
endinterface

interface pfa_csr_if;
   import pfa_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Fixed-partition allocator: load sizes, allocate by first/best/worst/next
// fit, restore free space from the original sizes.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat payload                          handshake
//   req_bus   in    func, part_index, size_value          valid/ready
//   rsp_bus   out   granted, block_index, space_left      valid/ready
//   csr_bus   in    index, data (fit_mode, part count)    valid/ready
//
// One item at a time. Load and unused codes pass from the request beat
// through the finish state to the output register; allocate scans the
// free-space memory in use (one registered read per cycle), then writes
// back; restore copies all MAX_PARTS entries, one entry copied per cycle.
// Reset (synchronous, active high) clears control state, the registers and
// the per-entry valid bits; an entry never loaded reads as zero.
// A response waiting in the output register does not block the next request
// beat; the item stalls only at its end until the output register frees.
// Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator (
   input  wire logic  clock,
   input  wire logic  reset,
   pfa_req_if.sink    req_bus,
   pfa_rsp_if.source  rsp_bus,
   pfa_csr_if.sink    csr_bus
);
   import pfa_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_WRITE   = 3'd2;
   localparam logic [2:0] ST_RESTORE = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   // free space and original size memories
   size_type free_mem [MAX_PARTS];
   size_type orig_mem [MAX_PARTS];

   logic [2:0]           state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   cnt_type              count_ff, count_in;
   idx_type              rover_ff, rover_in;
   logic [MAX_PARTS-1:0] valid_ff, valid_in;

   // scan state
   size_type req_size_ff, req_size_in;
   idx_type  addr_ff, addr_in;
   cnt_type  issued_ff, issued_in;
   logic     cmp_ff, cmp_in;
   idx_type  cmp_idx_ff, cmp_idx_in;
   logic     found_ff, found_in;
   idx_type  best_idx_ff, best_idx_in;
   size_type best_val_ff, best_val_in;

   // restore sweep
   cnt_type rs_cnt_ff, rs_cnt_in;
   logic    rs_pend_ff, rs_pend_in;
   idx_type rs_idx_ff, rs_idx_in;

   // result of the current item, then the output register
   logic     res_granted_ff, res_granted_in;
   idx_type  res_idx_ff, res_idx_in;
   size_type res_left_ff, res_left_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_granted_ff, rsp_granted_in;
   idx_type  rsp_idx_ff, rsp_idx_in;
   size_type rsp_left_ff, rsp_left_in;

   // memory ports
   size_type free_rd_ff;
   logic     free_rd_vld_ff;
   size_type orig_rd_ff;
   logic     free_we;
   idx_type  free_waddr;
   size_type free_wdata;
   logic     orig_we;

   logic     req_beat;
   logic     stop_mode;
   size_type word;
   logic     fits;
   size_type new_left;
   cnt_type  addr_next;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.granted     = rsp_granted_ff;
   assign rsp_bus.block_index = rsp_idx_ff;
   assign rsp_bus.space_left  = rsp_left_ff;

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign stop_mode = (mode_ff == FIT_FIRST) || (mode_ff == FIT_NEXT);
   // never-loaded entries read as zero
   assign word      = free_rd_vld_ff ? free_rd_ff : '0;
   assign fits      = cmp_ff && (word >= req_size_ff);
   assign new_left  = best_val_ff - req_size_ff;
   // circular address step over the partitions in use
   assign addr_next = ({1'b0, addr_ff} + CNT_BITS'(1) == count_ff) ?
                      '0 : {1'b0, addr_ff} + CNT_BITS'(1);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      count_in       = count_ff;
      rover_in       = rover_ff;
      valid_in       = valid_ff;
      req_size_in    = req_size_ff;
      addr_in        = addr_ff;
      issued_in      = issued_ff;
      cmp_in         = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_val_in    = best_val_ff;
      rs_cnt_in      = rs_cnt_ff;
      rs_pend_in     = 1'b0;
      rs_idx_in      = rs_idx_ff;
      res_granted_in = res_granted_ff;
      res_idx_in     = res_idx_ff;
      res_left_in    = res_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_left_in    = rsp_left_ff;
      free_we        = 1'b0;
      free_waddr     = req_bus.part_index;
      free_wdata     = req_bus.size_value;
      orig_we        = 1'b0;

      // register writes, only while idle by contract
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_FIT_MODE:   mode_in = csr_bus.data[1:0];
            REG_PART_COUNT: begin
               count_in = (CNT_BITS'(csr_bus.data) > CNT_BITS'(MAX_PARTS)) ?
                          CNT_BITS'(MAX_PARTS) : CNT_BITS'(csr_bus.data);
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               res_granted_in = 1'b0;
               res_idx_in     = '0;
               res_left_in    = '0;
               state_in       = ST_FINISH;
               case (req_bus.func)
                  FUNC_LOAD: begin
                     if ({1'b0, req_bus.part_index} < CNT_BITS'(MAX_PARTS)) begin
                        free_we  = 1'b1;
                        orig_we  = 1'b1;
                        valid_in[req_bus.part_index] = 1'b1;
                     end
                  end
                  FUNC_ALLOC: begin
                     req_size_in = req_bus.size_value;
                     found_in    = 1'b0;
                     issued_in   = '0;
                     addr_in     = (mode_ff == FIT_NEXT && {1'b0, rover_ff} < count_ff) ?
                                   rover_ff : '0;
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_RESTORE: begin
                     rs_cnt_in = '0;
                     rover_in  = '0;
                     state_in  = ST_RESTORE;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // compare the word read last cycle
            if (fits) begin
               if (!found_ff) begin
                  found_in    = 1'b1;
                  best_idx_in = cmp_idx_ff;
                  best_val_in = word;
               end else if ((mode_ff == FIT_BEST && word < best_val_ff) ||
                            (mode_ff == FIT_WORST && word > best_val_ff)) begin
                  best_idx_in = cmp_idx_ff;
                  best_val_in = word;
               end
            end
            // issue the next read
            if (issued_ff < count_ff && !(found_ff && stop_mode)) begin
               cmp_in     = 1'b1;
               cmp_idx_in = addr_ff;
               addr_in    = addr_next[IDX_BITS-1:0];
               issued_in  = issued_ff + CNT_BITS'(1);
            end
            if ((found_ff && stop_mode) || (!cmp_ff && issued_ff == count_ff)) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            // write back the chosen entry
            if (found_ff) begin
               free_we        = 1'b1;
               free_waddr     = best_idx_ff;
               free_wdata     = new_left;
               res_granted_in = 1'b1;
               res_idx_in     = best_idx_ff;
               res_left_in    = new_left;
               if (mode_ff == FIT_NEXT) begin
                  rover_in = best_idx_ff;
               end
            end
            state_in = ST_FINISH;
         end

         ST_RESTORE: begin
            if (rs_cnt_ff < CNT_BITS'(MAX_PARTS)) begin
               rs_pend_in = 1'b1;
               rs_idx_in  = rs_cnt_ff[IDX_BITS-1:0];
               rs_cnt_in  = rs_cnt_ff + CNT_BITS'(1);
            end
            if (rs_pend_ff) begin
               free_we    = 1'b1;
               free_waddr = rs_idx_ff;
               free_wdata = orig_rd_ff;
            end
            if (rs_cnt_ff == CNT_BITS'(MAX_PARTS) && !rs_pend_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_idx_in     = res_idx_ff;
               rsp_left_in    = res_left_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= FIT_FIRST;
         count_ff     <= '0;
         rover_ff     <= '0;
         valid_ff     <= '0;
         cmp_ff       <= 1'b0;
         found_ff     <= 1'b0;
         issued_ff    <= '0;
         rs_cnt_ff    <= '0;
         rs_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rover_ff     <= rover_in;
         valid_ff     <= valid_in;
         cmp_ff       <= cmp_in;
         found_ff     <= found_in;
         issued_ff    <= issued_in;
         rs_cnt_ff    <= rs_cnt_in;
         rs_pend_ff   <= rs_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_size_ff    <= req_size_in;
      addr_ff        <= addr_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_val_ff    <= best_val_in;
      rs_idx_ff      <= rs_idx_in;
      res_granted_ff <= res_granted_in;
      res_idx_ff     <= res_idx_in;
      res_left_ff    <= res_left_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_left_ff    <= rsp_left_in;
   end

   // free space memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      free_rd_ff     <= free_mem[addr_ff];
      free_rd_vld_ff <= valid_ff[addr_ff];
   end

   // original size memory
   always_ff @(posedge clock) begin
      if (orig_we) begin
         orig_mem[req_bus.part_index] <= req_bus.size_value;
      end
      orig_rd_ff <= orig_mem[rs_cnt_ff[IDX_BITS-1:0]];
   end

   // checks
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted_ff |-> {1'b0, rsp_idx_ff} < count_ff)
      else $error("granted block outside the partitions in use");

   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> rsp_idx_ff == '0 && rsp_left_ff == '0)
      else $error("refused or non-allocate response not zero");

   a_beat_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff != ST_IDLE)
      else $error("request beat did not start an item");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> issued_ff <= count_ff)
      else $error("scan issued more reads than partitions in use");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      rs_cnt_ff <= CNT_BITS'(MAX_PARTS))
      else $error("restore sweep ran past the last entry");

endmodule

`default_nettype wire
